[rtl/thst_pkg.sv]
// Shared types and constants of the thermal sensor tracker.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package thst_pkg;

   // Field widths
   localparam int IDX_W   = 2;
   localparam int TEMP_W  = 18;
   localparam int TREND_W = 19;
   localparam int TICK_W  = 16;
   localparam int TIME_W  = 48;
   localparam int OVR_W   = 2;

   // Sensors
   localparam int SLOT_COUNT          = 4;
   localparam int NUM_SENSORS_DEFAULT = 4;

   // Shared add/subtract unit
   localparam int ALU_W = TIME_W;

   // Divide by ten through a reciprocal: x < 2^22, q = (x * RECIP) >> RECIP_SHIFT
   localparam int X_W         = 22;
   localparam int RECIP_SHIFT = 25;
   localparam logic [X_W-1:0] RECIP = X_W'(((1 << RECIP_SHIFT) + 9) / 10);
   localparam int PROD_W      = 2 * X_W;

   // Level margins below each sensor limit
   localparam logic [TEMP_W-1:0] WARN_MARGIN = TEMP_W'(10000);
   localparam logic [TEMP_W-1:0] CRIT_MARGIN = TEMP_W'(5000);

   // Configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_LVL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THROT_LVL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_LVL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_0   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_1   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_2   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_3   = 3'd7;

   // Configuration reset values
   localparam logic [TICK_W-1:0] TICK_RESET      = TICK_W'(5000);
   localparam logic [TEMP_W-1:0] CRIT_LVL_RESET  = TEMP_W'(85000);
   localparam logic [TEMP_W-1:0] THROT_LVL_RESET = TEMP_W'(80000);
   localparam logic [TEMP_W-1:0] WARN_LVL_RESET  = TEMP_W'(75000);
   localparam logic [TEMP_W-1:0] LIMIT_RESET [SLOT_COUNT] =
      '{TEMP_W'(85000), TEMP_W'(80000), TEMP_W'(60000), TEMP_W'(45000)};

   // Overall state codes
   localparam logic [OVR_W-1:0] OVR_NORMAL   = 2'd0;
   localparam logic [OVR_W-1:0] OVR_WARM     = 2'd1;
   localparam logic [OVR_W-1:0] OVR_HOT      = 2'd2;
   localparam logic [OVR_W-1:0] OVR_CRITICAL = 2'd3;

   // Stream widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 192;
   localparam int RSP_USED_W  = TREND_W + 4 * TEMP_W + 2 * TIME_W + 1 + OVR_W;

   // One operation for the shared unit: a + b, or a - b when sub is set
   typedef struct packed {
      logic              sub;
      logic [ALU_W-1:0]  a;
      logic [ALU_W-1:0]  b;
   } alu_req_type;

endpackage

`default_nettype wire

[rtl/thst_alu.sv]
// Shared add/subtract unit of the thermal sensor tracker.
// Depends on thst_pkg (alu_req_type, ALU_W).
`timescale 1ns / 1ps
`default_nettype none

module thst_alu (
   input  thst_pkg::alu_req_type        op,
   output logic [thst_pkg::ALU_W-1:0]   res,
   output logic                         flag
);
   import thst_pkg::*;

   logic [ALU_W:0] sum;

   // flag is the carry out on add, the borrow (a < b) on subtract
   always_comb begin
      sum  = {1'b0, op.a} + (op.sub ? ~{1'b0, op.b} : {1'b0, op.b}) + (ALU_W+1)'(op.sub);
      res  = sum[ALU_W-1:0];
      flag = sum[ALU_W];
   end

endmodule

`default_nettype wire

[rtl/thst_div10.sv]
// Divide-by-ten for the running average: registered reciprocal multiply.
// Depends on thst_pkg (X_W, RECIP, RECIP_SHIFT). Quotient valid the cycle after x.
`timescale 1ns / 1ps
`default_nettype none

module thst_div10 (
   input  logic                          clock,
   input  logic [thst_pkg::X_W-1:0]      x,
   output logic [thst_pkg::TEMP_W-1:0]   q
);
   import thst_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(x) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // x stays below 2^22, so the truncated product is exact
   assign q = prod_ff[RECIP_SHIFT +: TEMP_W];

endmodule

`default_nettype wire

[rtl/thermal_sensor_tracker_top.sv]
// Thermal sensor tracker top: config registers, per-sensor stores, sequencer, result register.
// Depends on thst_pkg, thst_alu, thst_div10.
//
//   channel   dir  tvalid/tready handshake payload
//   req_*     in   tuser: sensor id, tdata: temperature
//   rsp_*     out  tuser: updated, tdata: statistics and overall state
//   csr_*     in   write enable, register index, write data (no handshake)
//
// A valid reading runs the per-sensor steps, commit, sensor walk and level checks;
// a zero reading (or unknown sensor) goes straight to the walk. One add/subtract
// unit does every subtract, compare and saturating add in turn.
// req_tready is high only while idle; it stays high with a result waiting.
// A finished item waits in its last step until the result register is free.
// Reset is synchronous and clears all sensor statistics at once.
`timescale 1ns / 1ps
`default_nettype none

module thermal_sensor_tracker_top #(
   parameter int NUM_SENSORS = thst_pkg::NUM_SENSORS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [thst_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [17:0] temperature
   input  logic [thst_pkg::IDX_W-1:0]           req_tuser,   // [1:0] sensor id
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [18:0] trend, [36:19] velocity, [54:37] acceleration, [72:55] peak_temp,
   // [90:73] average_temp, [138:91] warn_time, [186:139] crit_time,
   // [187] sensor_critical, [189:188] overall_state
   output logic [thst_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,   // [0] updated
   input  logic                                 csr_we,
   input  logic [thst_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [thst_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import thst_pkg::*;

   localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int CNT_W  = IDX_W + 1;

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
   localparam logic [ST_W-1:0] ST_TREND = 5'd1;
   localparam logic [ST_W-1:0] ST_VEL   = 5'd2;
   localparam logic [ST_W-1:0] ST_ACC   = 5'd3;
   localparam logic [ST_W-1:0] ST_ACC2  = 5'd4;
   localparam logic [ST_W-1:0] ST_PEAK  = 5'd5;
   localparam logic [ST_W-1:0] ST_AVG9  = 5'd6;
   localparam logic [ST_W-1:0] ST_AVGX  = 5'd7;
   localparam logic [ST_W-1:0] ST_WLVL  = 5'd8;
   localparam logic [ST_W-1:0] ST_CLVL  = 5'd9;
   localparam logic [ST_W-1:0] ST_WTIME = 5'd10;
   localparam logic [ST_W-1:0] ST_CTIME = 5'd11;
   localparam logic [ST_W-1:0] ST_COMMIT = 5'd12;
   localparam logic [ST_W-1:0] ST_WMAX  = 5'd13;
   localparam logic [ST_W-1:0] ST_WWARN = 5'd14;
   localparam logic [ST_W-1:0] ST_LCRIT = 5'd15;
   localparam logic [ST_W-1:0] ST_LHOT  = 5'd16;
   localparam logic [ST_W-1:0] ST_LWARN = 5'd17;
   localparam logic [ST_W-1:0] ST_DONE  = 5'd18;

   // Configuration
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TEMP_W-1:0] crit_lvl_ff, crit_lvl_in;
   logic [TEMP_W-1:0] throt_lvl_ff, throt_lvl_in;
   logic [TEMP_W-1:0] warn_lvl_ff, warn_lvl_in;
   logic [TEMP_W-1:0] limit_ff [SLOT_COUNT];
   logic [TEMP_W-1:0] limit_in [SLOT_COUNT];

   // Per-sensor statistics; the stored velocity doubles as the prior velocity
   logic [TEMP_W-1:0]  last_ff  [NUM_SENSORS];
   logic [TEMP_W-1:0]  last_in  [NUM_SENSORS];
   logic [TREND_W-1:0] trend_ff [NUM_SENSORS];
   logic [TREND_W-1:0] trend_in [NUM_SENSORS];
   logic [TEMP_W-1:0]  vel_ff   [NUM_SENSORS];
   logic [TEMP_W-1:0]  vel_in   [NUM_SENSORS];
   logic [TEMP_W-1:0]  acc_ff   [NUM_SENSORS];
   logic [TEMP_W-1:0]  acc_in   [NUM_SENSORS];
   logic [TEMP_W-1:0]  peak_ff  [NUM_SENSORS];
   logic [TEMP_W-1:0]  peak_in  [NUM_SENSORS];
   logic [TEMP_W-1:0]  avg_ff   [NUM_SENSORS];
   logic [TEMP_W-1:0]  avg_in   [NUM_SENSORS];
   logic [TIME_W-1:0]  wtime_ff [NUM_SENSORS];
   logic [TIME_W-1:0]  wtime_in [NUM_SENSORS];
   logic [TIME_W-1:0]  ctime_ff [NUM_SENSORS];
   logic [TIME_W-1:0]  ctime_in [NUM_SENSORS];
   logic               cflag_ff [NUM_SENSORS];
   logic               cflag_in [NUM_SENSORS];

   // Sequencer and working registers
   logic [ST_W-1:0]    state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [TEMP_W-1:0]  temp_ff, temp_in;
   logic               prev_nz_ff, prev_nz_in;
   logic [TREND_W-1:0] trend_w_ff, trend_w_in;
   logic [TEMP_W-1:0]  vel_w_ff, vel_w_in;
   logic               acc_neg_ff, acc_neg_in;
   logic [TEMP_W-1:0]  acc_w_ff, acc_w_in;
   logic [TEMP_W-1:0]  peak_w_ff, peak_w_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic               warn_hit_ff, warn_hit_in;
   logic               crit_hit_ff, crit_hit_in;
   logic [TIME_W-1:0]  wtime_w_ff, wtime_w_in;
   logic [TIME_W-1:0]  ctime_w_ff, ctime_w_in;
   logic [SIDX_W-1:0]  walk_ff, walk_in;
   logic [TEMP_W-1:0]  hottest_ff, hottest_in;
   logic               any_crit_ff, any_crit_in;
   logic               any_warn_ff, any_warn_in;
   logic               ge_crit_ff, ge_crit_in;
   logic               ge_hot_ff, ge_hot_in;
   logic               ge_warn_ff, ge_warn_in;
   // The item was a valid reading if the sensor's stores were committed; kept
   // as a flag so zero readings report zeros in the per-sensor fields.
   logic               item_ok_ff, item_ok_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   // Shared unit and divider
   alu_req_type        alu_op;
   logic [ALU_W-1:0]   alu_res;
   logic               alu_flag;
   logic [TEMP_W-1:0]  avg_q;

   // Stores are read at one address: the walk counter or the item's sensor
   logic               walking;
   logic [SIDX_W-1:0]  sel;
   logic [IDX_W-1:0]   lim_sel;
   logic [TEMP_W-1:0]  last_rd, vel_rd, peak_rd, avg_rd, lim_rd;
   logic [TIME_W-1:0]  wtime_rd, ctime_rd;
   logic               cflag_rd;
   logic               item_ok;
   logic               out_free;
   logic [OVR_W-1:0]   overall;

   thst_alu u_alu (
      .op   (alu_op),
      .res  (alu_res),
      .flag (alu_flag)
   );

   thst_div10 u_div10 (
      .clock (clock),
      .x     (x_ff),
      .q     (avg_q)
   );

   assign walking = (state_ff == ST_WMAX) || (state_ff == ST_WWARN);
   assign sel     = walking ? walk_ff : idx_ff[SIDX_W-1:0];
   assign lim_sel = walking ? IDX_W'(walk_ff) : idx_ff;

   assign last_rd  = last_ff[sel];
   assign vel_rd   = vel_ff[sel];
   assign peak_rd  = peak_ff[sel];
   assign avg_rd   = avg_ff[sel];
   assign wtime_rd = wtime_ff[sel];
   assign ctime_rd = ctime_ff[sel];
   assign cflag_rd = cflag_ff[sel];
   assign lim_rd   = limit_ff[lim_sel];

   assign item_ok  = (req_tdata[TEMP_W-1:0] != '0) &&
                     (CNT_W'(req_tuser) < CNT_W'(NUM_SENSORS));
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign item_ok_in = (state_ff == ST_IDLE && req_tvalid) ? item_ok : item_ok_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      if (any_crit_ff || ge_crit_ff) begin
         overall = OVR_CRITICAL;
      end else if (ge_hot_ff) begin
         overall = OVR_HOT;
      end else if (any_warn_ff || ge_warn_ff) begin
         overall = OVR_WARM;
      end else begin
         overall = OVR_NORMAL;
      end
   end

   // Configuration writes
   always_comb begin
      tick_in      = tick_ff;
      crit_lvl_in  = crit_lvl_ff;
      throt_lvl_in = throt_lvl_ff;
      warn_lvl_in  = warn_lvl_ff;
      limit_in     = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TICK:      tick_in      = csr_wdata[TICK_W-1:0];
            CSR_CRIT_LVL:  crit_lvl_in  = csr_wdata[TEMP_W-1:0];
            CSR_THROT_LVL: throt_lvl_in = csr_wdata[TEMP_W-1:0];
            CSR_WARN_LVL:  warn_lvl_in  = csr_wdata[TEMP_W-1:0];
            CSR_LIMIT_0, CSR_LIMIT_1, CSR_LIMIT_2, CSR_LIMIT_3: begin
               limit_in[csr_index[IDX_W-1:0]] = csr_wdata[TEMP_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // Shared unit operand selection
   always_comb begin
      alu_op = '0;
      case (state_ff)
         ST_TREND: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(temp_ff);
            alu_op.b   = ALU_W'(last_rd);
         end
         ST_VEL: begin
            alu_op.sub = 1'b1;
            alu_op.a   = trend_w_ff[TREND_W-1] ? ALU_W'(last_rd) : ALU_W'(temp_ff);
            alu_op.b   = trend_w_ff[TREND_W-1] ? ALU_W'(temp_ff) : ALU_W'(last_rd);
         end
         ST_ACC: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(vel_w_ff);
            alu_op.b   = ALU_W'(vel_rd);
         end
         ST_ACC2: begin
            alu_op.sub = 1'b1;
            alu_op.a   = acc_neg_ff ? ALU_W'(vel_rd) : ALU_W'(vel_w_ff);
            alu_op.b   = acc_neg_ff ? ALU_W'(vel_w_ff) : ALU_W'(vel_rd);
         end
         ST_PEAK: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(peak_rd);
            alu_op.b   = ALU_W'(temp_ff);
         end
         ST_AVG9: begin
            alu_op.a = ALU_W'({avg_rd, 3'b000});
            alu_op.b = ALU_W'(avg_rd);
         end
         ST_AVGX: begin
            alu_op.a = ALU_W'(x_ff);
            alu_op.b = ALU_W'(temp_ff);
         end
         // t >= limit - margin, written as t + margin >= limit (no underflow)
         ST_WLVL: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(temp_ff) + ALU_W'(WARN_MARGIN);
            alu_op.b   = ALU_W'(lim_rd);
         end
         ST_CLVL: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(temp_ff) + ALU_W'(CRIT_MARGIN);
            alu_op.b   = ALU_W'(lim_rd);
         end
         ST_WTIME: begin
            alu_op.a = wtime_rd;
            alu_op.b = ALU_W'(tick_ff);
         end
         ST_CTIME: begin
            alu_op.a = ctime_rd;
            alu_op.b = ALU_W'(tick_ff);
         end
         ST_WMAX: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(last_rd);
            alu_op.b   = ALU_W'(hottest_ff);
         end
         ST_WWARN: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(last_rd) + ALU_W'(WARN_MARGIN);
            alu_op.b   = ALU_W'(lim_rd);
         end
         ST_LCRIT: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(hottest_ff);
            alu_op.b   = ALU_W'(crit_lvl_ff);
         end
         ST_LHOT: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(hottest_ff);
            alu_op.b   = ALU_W'(throt_lvl_ff);
         end
         ST_LWARN: begin
            alu_op.sub = 1'b1;
            alu_op.a   = ALU_W'(hottest_ff);
            alu_op.b   = ALU_W'(warn_lvl_ff);
         end
         default: ;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      temp_in     = temp_ff;
      prev_nz_in  = prev_nz_ff;
      trend_w_in  = trend_w_ff;
      vel_w_in    = vel_w_ff;
      acc_neg_in  = acc_neg_ff;
      acc_w_in    = acc_w_ff;
      peak_w_in   = peak_w_ff;
      x_in        = x_ff;
      warn_hit_in = warn_hit_ff;
      crit_hit_in = crit_hit_ff;
      wtime_w_in  = wtime_w_ff;
      ctime_w_in  = ctime_w_ff;
      walk_in     = walk_ff;
      hottest_in  = hottest_ff;
      any_crit_in = any_crit_ff;
      any_warn_in = any_warn_ff;
      ge_crit_in  = ge_crit_ff;
      ge_hot_in   = ge_hot_ff;
      ge_warn_in  = ge_warn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      last_in  = last_ff;
      trend_in = trend_ff;
      vel_in   = vel_ff;
      acc_in   = acc_ff;
      peak_in  = peak_ff;
      avg_in   = avg_ff;
      wtime_in = wtime_ff;
      ctime_in = ctime_ff;
      cflag_in = cflag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in      = req_tuser;
               temp_in     = req_tdata[TEMP_W-1:0];
               walk_in     = '0;
               hottest_in  = '0;
               any_crit_in = 1'b0;
               any_warn_in = 1'b0;
               state_in    = item_ok ? ST_TREND : ST_WMAX;
            end
         end
         ST_TREND: begin
            prev_nz_in = (last_rd != '0);
            trend_w_in = alu_res[TREND_W-1:0];
            state_in   = ST_VEL;
         end
         ST_VEL: begin
            vel_w_in = alu_res[TEMP_W-1:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_neg_in = alu_flag;
            state_in   = ST_ACC2;
         end
         ST_ACC2: begin
            acc_w_in = alu_res[TEMP_W-1:0];
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            peak_w_in = alu_flag ? temp_ff : peak_rd;
            state_in  = ST_AVG9;
         end
         ST_AVG9: begin
            x_in     = alu_res[X_W-1:0];
            state_in = ST_AVGX;
         end
         ST_AVGX: begin
            x_in     = alu_res[X_W-1:0];
            state_in = ST_WLVL;
         end
         ST_WLVL: begin
            warn_hit_in = !alu_flag;
            state_in    = ST_CLVL;
         end
         ST_CLVL: begin
            crit_hit_in = !alu_flag;
            state_in    = ST_WTIME;
         end
         ST_WTIME: begin
            wtime_w_in = alu_flag ? '1 : alu_res;
            state_in   = ST_CTIME;
         end
         ST_CTIME: begin
            ctime_w_in = alu_flag ? '1 : alu_res;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            last_in[sel] = temp_ff;
            if (prev_nz_ff) begin
               trend_in[sel] = trend_w_ff;
               vel_in[sel]   = vel_w_ff;
               acc_in[sel]   = acc_w_ff;
            end
            peak_in[sel] = peak_w_ff;
            avg_in[sel]  = (avg_rd == '0) ? temp_ff : avg_q;
            if (warn_hit_ff) begin
               wtime_in[sel] = wtime_w_ff;
            end
            if (crit_hit_ff) begin
               ctime_in[sel] = ctime_w_ff;
            end
            cflag_in[sel] = crit_hit_ff;
            state_in      = ST_WMAX;
         end
         ST_WMAX: begin
            if (!alu_flag) begin
               hottest_in = last_rd;
            end
            if (cflag_rd) begin
               any_crit_in = 1'b1;
            end
            state_in = ST_WWARN;
         end
         ST_WWARN: begin
            // flagged sensors and sensors never read do not count as warm
            if (!alu_flag && (last_rd != '0) && !cflag_rd) begin
               any_warn_in = 1'b1;
            end
            if (walk_ff == SIDX_W'(NUM_SENSORS - 1)) begin
               state_in = ST_LCRIT;
            end else begin
               walk_in  = walk_ff + 1'b1;
               state_in = ST_WMAX;
            end
         end
         ST_LCRIT: begin
            ge_crit_in = !alu_flag;
            state_in   = ST_LHOT;
         end
         ST_LHOT: begin
            ge_hot_in = !alu_flag;
            state_in  = ST_LWARN;
         end
         ST_LWARN: begin
            ge_warn_in = !alu_flag;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = item_ok_ff;
               state_in     = ST_IDLE;
               if (item_ok_ff) begin
                  rsp_data_in = RSP_TDATA_W'({overall, cflag_rd, ctime_rd, wtime_rd,
                                              avg_rd, peak_rd, acc_ff[sel], vel_rd,
                                              trend_ff[sel]});
               end else begin
                  rsp_data_in = RSP_TDATA_W'({overall, {(RSP_USED_W - OVR_W){1'b0}}});
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         item_ok_ff   <= 1'b0;
         tick_ff      <= TICK_RESET;
         crit_lvl_ff  <= CRIT_LVL_RESET;
         throt_lvl_ff <= THROT_LVL_RESET;
         warn_lvl_ff  <= WARN_LVL_RESET;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            limit_ff[i] <= LIMIT_RESET[i];
         end
         for (int s = 0; s < NUM_SENSORS; s++) begin
            last_ff[s]  <= '0;
            trend_ff[s] <= '0;
            vel_ff[s]   <= '0;
            acc_ff[s]   <= '0;
            peak_ff[s]  <= '0;
            avg_ff[s]   <= '0;
            wtime_ff[s] <= '0;
            ctime_ff[s] <= '0;
            cflag_ff[s] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         item_ok_ff   <= item_ok_in;
         tick_ff      <= tick_in;
         crit_lvl_ff  <= crit_lvl_in;
         throt_lvl_ff <= throt_lvl_in;
         warn_lvl_ff  <= warn_lvl_in;
         limit_ff     <= limit_in;
         last_ff      <= last_in;
         trend_ff     <= trend_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         peak_ff      <= peak_in;
         avg_ff       <= avg_in;
         wtime_ff     <= wtime_in;
         ctime_ff     <= ctime_in;
         cflag_ff     <= cflag_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      temp_ff     <= temp_in;
      prev_nz_ff  <= prev_nz_in;
      trend_w_ff  <= trend_w_in;
      vel_w_ff    <= vel_w_in;
      acc_neg_ff  <= acc_neg_in;
      acc_w_ff    <= acc_w_in;
      peak_w_ff   <= peak_w_in;
      x_ff        <= x_in;
      warn_hit_ff <= warn_hit_in;
      crit_hit_ff <= crit_hit_in;
      wtime_w_ff  <= wtime_w_in;
      ctime_w_ff  <= ctime_w_in;
      walk_ff     <= walk_in;
      hottest_ff  <= hottest_in;
      any_crit_ff <= any_crit_in;
      any_warn_ff <= any_warn_in;
      ge_crit_ff  <= ge_crit_in;
      ge_hot_ff   <= ge_hot_in;
      ge_warn_ff  <= ge_warn_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

[rtl/thst_checker.sv]
// Port-level checks of the thermal sensor tracker, bound to the top level.
// Depends on thst_pkg and thermal_sensor_tracker_top.
`timescale 1ns / 1ps
`default_nettype none

module thst_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [thst_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 rsp_tuser
);
   import thst_pkg::*;

   logic req_acc;

   assign req_acc = req_tvalid && req_tready;

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("input accepted while an item is in work");

   // no item finishes in the cycle after it is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // ignored reading reports only the overall state
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_USED_W-OVR_W-1:0] == '0)
      else $error("ignored reading carries statistics");

   // a sensor over its own critical level forces the critical state
   a_crit_overall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_USED_W-OVR_W-1] |->
         rsp_tdata[RSP_USED_W-1:RSP_USED_W-OVR_W] == OVR_CRITICAL)
      else $error("sensor critical but overall state is not critical");

endmodule

bind thermal_sensor_tracker_top thst_checker u_thst_checker (.*);

`default_nettype wire
